FILE: rtl/fops_pkg.sv
// ----------------------------------------------------------------------------
// fops_pkg
// Shared types and constants of the first-occurrence pattern search core.
// ----------------------------------------------------------------------------
`default_nettype none

package fops_pkg;

    // field widths of the words on the channels
    localparam int BYTE_W          = 8;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int LEN_W           = 5;
    localparam int OUT_POS_W       = 16;
    localparam int PAT_REG_BYTES   = 8;
    localparam int PAT_STORE_BYTES = 2 * PAT_REG_BYTES;

    // range covered by the pattern length register
    localparam int LEN_SPAN = 2 ** LEN_W;

    // defaults of the top level parameters
    localparam int DEF_MAX_PATTERN_BYTES = 16;
    localparam int DEF_POSITION_BITS     = 16;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } cfg_index_t;

    // control handed to each window cell
    typedef struct packed {
        logic              shift_en;
        logic              active;
        logic [BYTE_W-1:0] pat_byte;
    } fops_cell_ctrl_t;

endpackage : fops_pkg

`default_nettype wire

FILE: rtl/fops_if.sv
// ----------------------------------------------------------------------------
// fops channel interfaces
// Valid/ready channels for text bytes, search results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface fops_in_if
    import fops_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface : fops_in_if

interface fops_out_if
    import fops_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [OUT_POS_W-1:0] match_position;
    logic                 text_too_long;

    modport source (output valid, output found, output match_position,
                    output text_too_long, input ready);
    modport sink   (input valid, input found, input match_position,
                    input text_too_long, output ready);
endinterface : fops_out_if

interface fops_cfg_if
    import fops_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface : fops_cfg_if

`default_nettype wire

FILE: rtl/fops_cell.sv
// ----------------------------------------------------------------------------
// fops_cell
// One window cell: holds one text byte, passes it on, compares the byte
// entering it against its pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fops_cell
    import fops_pkg::*;
(
    input  wire logic              clk,
    input  wire fops_cell_ctrl_t   ctrl,
    input  wire logic [BYTE_W-1:0] byte_in,
    output logic      [BYTE_W-1:0] byte_out,
    output logic                   hit
);

    logic [BYTE_W-1:0] byte_reg;

    // window byte, shifts toward older cells on each accepted word
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    // compare the byte this cell holds after the shift
    assign hit      = !ctrl.active || (byte_in == ctrl.pat_byte);
    assign byte_out = byte_reg;

endmodule : fops_cell

`default_nettype wire

FILE: rtl/first_occurrence_pattern_search_core.sv
// ----------------------------------------------------------------------------
// first_occurrence_pattern_search_core
// Streams text bytes through a row of window cells and reports the start of
// the first occurrence of the configured pattern on the last byte.
// ----------------------------------------------------------------------------
// The registered result is valid in the cycle after the last byte is accepted.
// One text byte per cycle unless stalled; all window cells compare in parallel.
// A result waiting in the output register does not block input unless it is
// stalled while a new byte arrives.
// Reset clears the pattern registers, byte count and match state.
`default_nettype none

module first_occurrence_pattern_search_core
    import fops_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
    parameter int POSITION_BITS     = DEF_POSITION_BITS
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    fops_in_if.sink     text_in,
    fops_out_if.source  result_out,
    fops_cfg_if.sink    cfg
);

    localparam int CNT_W     = POSITION_BITS + 1;
    localparam int EXT_BYTES = LEN_SPAN + MAX_PATTERN_BYTES;
    localparam int SH_W      = LEN_W + 1;

    localparam logic [CNT_W-1:0] POS_LIMIT = {1'b1, {POSITION_BITS{1'b0}}};
    localparam logic [CNT_W-1:0] COUNT_CAP = {1'b1, {(POSITION_BITS-1){1'b0}}, 1'b1};
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // configuration registers
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]      pat_len_reg;

    // search state
    logic [CNT_W-1:0]         cnt_reg;
    logic                     match_seen_reg;
    logic [POSITION_BITS-1:0] start_reg;

    // result register
    logic                     out_valid_reg;
    logic                     found_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic                     too_long_reg;

    logic                     accept;
    logic                     finish;
    logic [CNT_W-1:0]         cnt_next;
    logic                     len_ok;
    logic                     window_hit;
    logic                     new_match;
    logic                     too_long_now;
    logic [POSITION_BITS-1:0] start_next;
    logic                     seen_now;
    logic [POSITION_BITS-1:0] start_now;

    logic [EXT_BYTES*BYTE_W-1:0] pat_ext;
    logic [EXT_BYTES*BYTE_W-1:0] pat_aligned;
    logic [SH_W-1:0]             pat_shift;

    fops_cell_ctrl_t          cell_ctrl [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0]        cell_byte [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] cell_hit;

    // handshakes
    assign cfg.ready     = 1'b1;
    assign text_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = text_in.valid && text_in.ready;
    assign finish        = accept && text_in.last_byte;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                CFG_PAT_LOW:  pat_low_reg  <= cfg.write_data;
                CFG_PAT_HIGH: pat_high_reg <= cfg.write_data;
                CFG_PAT_LEN:  pat_len_reg  <= cfg.write_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // pattern bytes laid out reversed, so one shift lines them up with the cells
    always_comb
    begin
        pat_ext = '0;
        for (int m = 0; m < PAT_REG_BYTES; m++)
        begin
            pat_ext[(LEN_SPAN-1-m)*BYTE_W +: BYTE_W] = pat_low_reg[m*BYTE_W +: BYTE_W];
            pat_ext[(LEN_SPAN-1-PAT_REG_BYTES-m)*BYTE_W +: BYTE_W] =
                pat_high_reg[m*BYTE_W +: BYTE_W];
        end
    end

    assign pat_shift   = SH_W'(LEN_SPAN) - {1'b0, pat_len_reg};
    assign pat_aligned = pat_ext >> {pat_shift, 3'b000};

    // row of window cells, newest byte in cell 0
    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++)
    begin : g_cell
        assign cell_ctrl[j].shift_en = accept;
        assign cell_ctrl[j].active   = int'(pat_len_reg) > j;
        assign cell_ctrl[j].pat_byte = pat_aligned[j*BYTE_W +: BYTE_W];

        if (j == 0)
        begin : g_head
            fops_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl[j]),
                .byte_in  (text_in.text_byte),
                .byte_out (cell_byte[j]),
                .hit      (cell_hit[j])
            );
        end
        else
        begin : g_body
            fops_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl[j]),
                .byte_in  (cell_byte[j-1]),
                .byte_out (cell_byte[j]),
                .hit      (cell_hit[j])
            );
        end
    end

    // match decision for the word being accepted
    assign cnt_next     = (cnt_reg < COUNT_CAP) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign len_ok       = (pat_len_reg != '0) && (int'(pat_len_reg) <= MAX_PATTERN_BYTES);
    assign window_hit   = &cell_hit;
    assign too_long_now = cnt_next > POS_LIMIT;
    assign new_match    = !match_seen_reg && len_ok && window_hit
                          && (cnt_next >= CNT_W'(pat_len_reg));
    assign start_next   = too_long_now ? POS_MAX
                          : POSITION_BITS'(cnt_next - CNT_W'(pat_len_reg));
    assign seen_now     = match_seen_reg || new_match;
    assign start_now    = new_match ? start_next : start_reg;

    // search state, cleared after the last byte of a text
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            match_seen_reg <= 1'b0;
            start_reg      <= '0;
        end
        else if (finish)
        begin
            cnt_reg        <= '0;
            match_seen_reg <= 1'b0;
            start_reg      <= '0;
        end
        else if (accept)
        begin
            cnt_reg        <= cnt_next;
            match_seen_reg <= seen_now;
            start_reg      <= start_now;
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            too_long_reg <= too_long_now;
            if (pat_len_reg == '0)
            begin
                found_reg <= 1'b1;
                pos_reg   <= '0;
            end
            else
            begin
                found_reg <= seen_now;
                pos_reg   <= seen_now ? start_now : '0;
            end
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.found          = found_reg;
    assign result_out.match_position = OUT_POS_W'(pos_reg);
    assign result_out.text_too_long  = too_long_reg;

    // checks
    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg)
        else $error("no result word after last byte");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (cnt_reg == '0) && !match_seen_reg)
        else $error("search state not cleared after last byte");

    a_match_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(match_seen_reg) |-> $past(accept))
        else $error("match recorded without an accepted byte");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (pos_reg == '0))
        else $error("position nonzero on a miss");

endmodule : first_occurrence_pattern_search_core

`default_nettype wire

FILE: tb/tb_first_occurrence_pattern_search_core.sv
// ----------------------------------------------------------------------------
// tb_first_occurrence_pattern_search_core
// Streams texts through the search core and checks every result word against
// a bit-accurate predictor of the first match. Covers the empty, full-length
// and overlong patterns, texts too short to match, a register change in the
// middle of a text and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_first_occurrence_pattern_search_core;
    import fops_pkg::*;

    localparam int POS_LIMIT    = 1 << DEF_POSITION_BITS;
    localparam int COUNT_CAP    = POS_LIMIT + 1;
    localparam int WINDOW_BYTES = DEF_MAX_PATTERN_BYTES;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int MODE_BYTES   = 145;
    localparam int TIMEOUT_NS   = 3_000_000;

    // index past the last register, writes to it are dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    typedef struct packed {
        logic                 found;
        logic [OUT_POS_W-1:0] position;
        logic                 too_long;
    } search_answer_t;

    // predictor of the first match and store of the answers still due
    class first_match_tracker;
        logic [CFG_DATA_W-1:0] pat_low;
        logic [CFG_DATA_W-1:0] pat_high;
        logic [LEN_W-1:0]      pat_len;
        logic [BYTE_W-1:0]     window [WINDOW_BYTES];
        int unsigned           seen_count;
        bit                    have_match;
        int unsigned           match_start;
        search_answer_t        answers_due[$];
        int unsigned           mismatches;
        int unsigned           answers_checked;

        function new();
            pat_low         = '0;
            pat_high        = '0;
            pat_len         = '0;
            mismatches      = 0;
            answers_checked = 0;
            clear();
        endfunction

        function void clear();
            foreach (window[i])
                window[i] = '0;
            seen_count  = 0;
            have_match  = 1'b0;
            match_start = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PAT_LOW:  pat_low  = data;
                CFG_PAT_HIGH: pat_high = data;
                CFG_PAT_LEN:  pat_len  = data[LEN_W-1:0];
                default:      ;
            endcase
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b, logic last);
            int unsigned                len;
            int                         i;
            bit                         hit;
            logic [2*CFG_DATA_W-1:0]    pat;
            search_answer_t             ans;
            len = pat_len;
            pat = {pat_high, pat_low};
            for (i = WINDOW_BYTES - 1; i > 0; i--)
                window[i] = window[i-1];
            window[0] = b;
            if (seen_count < COUNT_CAP)
                seen_count++;
            // compare newest bytes with the pattern, first hit only
            if (!have_match && len > 0 && len <= WINDOW_BYTES && seen_count >= len)
            begin
                hit = 1'b1;
                for (i = 0; i < len; i++)
                    if (window[len-1-i] != pat[BYTE_W*i +: BYTE_W])
                        hit = 1'b0;
                if (hit)
                begin
                    have_match  = 1'b1;
                    match_start = (seen_count > POS_LIMIT) ? POS_LIMIT - 1
                                                           : seen_count - len;
                end
            end
            // last byte closes the text with one answer
            if (last)
            begin
                ans.too_long = (seen_count > POS_LIMIT);
                ans.found    = (len == 0) || have_match;
                ans.position = (len != 0 && have_match) ? OUT_POS_W'(match_start) : '0;
                answers_due.push_back(ans);
                clear();
            end
        endfunction

        function void check_answer(logic f, logic [OUT_POS_W-1:0] p, logic t);
            search_answer_t want;
            answers_checked++;
            if (answers_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result found=%0b position=%0d too_long=%0b",
                         $time, f, p, t);
                return;
            end
            want = answers_due.pop_front();
            if (f !== want.found)
            begin
                mismatches++;
                $display("%0t: found expected %0b actual %0b", $time, want.found, f);
            end
            if (p !== want.position)
            begin
                mismatches++;
                $display("%0t: match_position expected %0d actual %0d",
                         $time, want.position, p);
            end
            if (t !== want.too_long)
            begin
                mismatches++;
                $display("%0t: text_too_long expected %0b actual %0b",
                         $time, want.too_long, t);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    fops_in_if  text_in ();
    fops_out_if result_out ();
    fops_cfg_if cfg ();

    first_occurrence_pattern_search_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .result_out (result_out),
        .cfg        (cfg)
    );

    first_match_tracker tracker = new();

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_req    = 1'b0;
    bit          hold_ack    = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned bytes_sent  = 0;
    int unsigned texts_sent  = 0;
    int unsigned reg_writes  = 0;

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side ready, with random idling and an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack         <= hold_req;
            hold_left        <= HOLD_CYCLES;
            result_out.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left        <= hold_left - 1;
            result_out.ready <= 1'b0;
        end
        else
            result_out.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_out.valid && result_out.ready)
            tracker.check_answer(result_out.found, result_out.match_position,
                                 result_out.text_too_long);
    end

    // one text word, with random idle cycles before it
    task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            text_in.valid <= 1'b0;
            @(posedge clk);
        end
        text_in.valid     <= 1'b1;
        text_in.text_byte <= b;
        text_in.last_byte <= last;
        do
            @(posedge clk);
        while (!text_in.ready);
        tracker.take_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_text(byte_q_t text);
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
        texts_sent++;
    endtask

    // drain results and let the last word settle before a register write
    task automatic settle();
        text_in.valid <= 1'b0;
        while (tracker.answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write, valid dropped for a cycle afterwards
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg.valid      <= 1'b1;
        cfg.reg_index  <= idx;
        cfg.write_data <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        tracker.write_register(idx, data);
        reg_writes++;
        @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pattern_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // random byte, often taken from the live pattern to provoke partial matches
    function automatic logic [BYTE_W-1:0] noise_byte();
        logic [2*CFG_DATA_W-1:0] pat;
        int unsigned             span;
        pat  = {tracker.pat_high, tracker.pat_low};
        span = (tracker.pat_len > 0 && tracker.pat_len <= WINDOW_BYTES) ?
               tracker.pat_len : PAT_STORE_BYTES;
        if ($urandom_range(0, 1))
            return pat[BYTE_W*$urandom_range(0, span - 1) +: BYTE_W];
        return BYTE_W'($urandom);
    endfunction

    task automatic random_config();
        logic [CFG_DATA_W-1:0] len_word;
        settle();
        write_reg(CFG_PAT_LOW, pattern_word());
        write_reg(CFG_PAT_HIGH, pattern_word());
        // upper bits of the length word are don't-care
        len_word = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       len_word[LEN_W-1:0] = '0;
            1:       len_word[LEN_W-1:0] = LEN_W'(WINDOW_BYTES);
            2:       len_word[LEN_W-1:0] = LEN_W'($urandom_range(WINDOW_BYTES + 1,
                                                                 LEN_SPAN - 1));
            default: len_word[LEN_W-1:0] = LEN_W'($urandom_range(1, 4));
        endcase
        write_reg(CFG_PAT_LEN, len_word);
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_UNUSED, {$urandom, $urandom});
    endtask

    // noise, mostly a planted copy of the pattern, more noise
    task automatic send_random_text();
        byte_q_t                 text;
        logic [2*CFG_DATA_W-1:0] pat;
        int unsigned             len;
        int unsigned             i;
        pat = {tracker.pat_high, tracker.pat_low};
        len = tracker.pat_len;
        repeat ($urandom_range(0, 10)) text.push_back(noise_byte());
        if ($urandom_range(0, 9) < 7 && len > 0 && len <= WINDOW_BYTES)
            for (i = 0; i < len; i++)
                text.push_back(pat[BYTE_W*i +: BYTE_W]);
        repeat ($urandom_range(0, 10)) text.push_back(noise_byte());
        if (text.size() == 0)
            text.push_back(noise_byte());
        send_text(text);
    endtask

    // stimulus
    initial
    begin
        byte_q_t     dtext;
        int          mode;
        int unsigned mode_start;
        int unsigned i;

        rst_n              = 1'b0;
        text_in.valid      = 1'b0;
        text_in.text_byte  = '0;
        text_in.last_byte  = 1'b0;
        cfg.valid          = 1'b0;
        cfg.reg_index      = '0;
        cfg.write_data     = '0;
        result_out.ready   = 1'b0;
        tx_idle_pct        = 31;
        rx_idle_pct        = 74;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern out of reset matches at zero
        dtext = '{8'h00};
        send_text(dtext);

        // zero pattern against a zero window: too short, then a real hit
        settle();
        write_reg(CFG_PAT_LEN, 64'd2);
        dtext = '{8'h00};
        send_text(dtext);
        dtext = '{8'h05, 8'h00, 8'h00};
        send_text(dtext);

        // full-length pattern of all-ones and all-zeros bytes
        settle();
        write_reg(CFG_PAT_LOW, '1);
        write_reg(CFG_PAT_HIGH, '0);
        write_reg(CFG_PAT_LEN, 64'(WINDOW_BYTES));
        dtext = {};
        for (i = 0; i < WINDOW_BYTES; i++)
            dtext.push_back(i < PAT_REG_BYTES ? 8'hFF : 8'h00);
        send_text(dtext);

        // overlong length never matches
        settle();
        write_reg(CFG_PAT_LEN, '1);
        dtext = '{8'hFF, 8'hFF};
        send_text(dtext);

        // register change inside a text keeps the earlier hit
        settle();
        write_reg(CFG_PAT_LOW, 64'hAB);
        write_reg(CFG_PAT_LEN, 64'd1);
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        send_byte(8'hAB, 1'b0);
        settle();
        write_reg(CFG_PAT_LEN, 64'd3);
        send_byte(8'hCD, 1'b1);
        texts_sent++;

        // random texts under three idling patterns
        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:       begin tx_idle_pct = 31; rx_idle_pct = 74; end
                1:       begin tx_idle_pct = 74; rx_idle_pct = 31; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            if (mode == 2)
            begin
                // stall the result side while short texts keep coming
                hold_req <= ~hold_req;
                repeat (40)
                begin
                    dtext = {};
                    repeat ($urandom_range(1, 3)) dtext.push_back(noise_byte());
                    send_text(dtext);
                end
            end
            mode_start = bytes_sent;
            i          = 0;
            while (bytes_sent - mode_start < MODE_BYTES)
            begin
                if (i % 3 == 0)
                    random_config();
                send_random_text();
                i++;
            end
        end

        // trailing bytes with no last mark give no result
        repeat (3) send_byte(noise_byte(), 1'b0);
        text_in.valid <= 1'b0;

        while (tracker.answers_due.size() != 0)
            @(posedge clk);
        repeat (2 * DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d texts in %0d bytes, %0d results checked, %0d register writes",
                 texts_sent, bytes_sent, tracker.answers_checked, reg_writes);
        $display("patterns from empty to overlong, a mid-text length change, a long stall");
        if (tracker.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
rtl/fops_pkg.sv
rtl/fops_if.sv
rtl/fops_cell.sv
rtl/first_occurrence_pattern_search_core.sv
tb/tb_first_occurrence_pattern_search_core.sv
